[hw/rtl/kwp2000_frame_receiver_macros.svh]
// Assertion macros for the frame receiver RTL, included by kwp_deframer.
// Needs nothing else; files that assert include it by name.
`ifndef KWP2000_FRAME_RECEIVER_MACROS_SVH
`define KWP2000_FRAME_RECEIVER_MACROS_SVH

// Condition and check in the same cycle.
`define KWP_ASSERT_NOW(label, clk, rst, cond, chk, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
      else $error(msg);

// Condition in one cycle, check in the next.
`define KWP_ASSERT_NEXT(label, clk, rst, cond, chk, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
      else $error(msg);

`endif

[hw/rtl/kwp_pkg.sv]
// Shared types and constants of the ISO 14230 frame receiver.
// Used by kwp_deframer and kwp2000_frame_receiver; depends on nothing.
`default_nettype none

package kwp_pkg;

   typedef enum logic [1:0] {
      STATUS_MORE  = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   // Format byte fields.
   localparam logic [7:0] FMT_MODE_MASK = 8'hC0;
   localparam logic [7:0] FMT_MODE_CARB = 8'h40;
   localparam logic [7:0] FMT_ADDR_BIT  = 8'h80;
   localparam logic [7:0] FMT_LEN_MASK  = 8'h3F;

   typedef struct packed {
      status_type  status;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  payload_length;
      logic        has_addresses;
      logic [7:0]  target_address;
      logic [7:0]  source_address;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/kwp_deframer.sv]
// Frame state registers and per-byte deframing logic.
// Depends on kwp_pkg and kwp2000_frame_receiver_macros.svh.
`default_nettype none

`include "kwp2000_frame_receiver_macros.svh"

module kwp_deframer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_valid,
   input  wire logic [7:0]         step_byte,
   output      kwp_pkg::result_type step_result
);

   logic [2:0] header_index_ff,  header_index_in;
   logic [2:0] header_length_ff, header_length_in;
   logic [7:0] data_length_ff,   data_length_in;
   logic [7:0] data_index_ff,    data_index_in;
   logic [7:0] running_sum_ff,   running_sum_in;
   logic [7:0] target_ff,        target_in;
   logic [7:0] source_ff,        source_in;
   logic       address_ff,       address_in;

   logic       first_byte;
   logic       carb;
   logic       addr_eff;
   logic [2:0] hlen_eff;
   logic [7:0] dlen_eff;
   logic [7:0] fmt_len;
   logic [2:0] hidx_next;
   logic [7:0] sum_next;

   always_comb begin
      fmt_len    = step_byte & kwp_pkg::FMT_LEN_MASK;
      first_byte = (header_index_ff == 3'd0);
      carb       = first_byte &&
                   ((step_byte & kwp_pkg::FMT_MODE_MASK) == kwp_pkg::FMT_MODE_CARB);
      // On the format byte the header shape comes from the byte itself.
      addr_eff   = first_byte ? ((step_byte & kwp_pkg::FMT_ADDR_BIT) != 8'd0) : address_ff;
      hlen_eff   = first_byte ? (3'd1 + (addr_eff ? 3'd2 : 3'd0) +
                                 ((fmt_len == 8'd0) ? 3'd1 : 3'd0))
                              : header_length_ff;
      dlen_eff   = first_byte ? fmt_len : data_length_ff;
      hidx_next  = header_index_ff + 3'd1;
      sum_next   = running_sum_ff + step_byte;

      header_index_in  = header_index_ff;
      header_length_in = hlen_eff;
      data_length_in   = dlen_eff;
      data_index_in    = data_index_ff;
      running_sum_in   = running_sum_ff;
      target_in        = target_ff;
      source_in        = source_ff;
      address_in       = addr_eff;

      step_result                = '0;
      step_result.status         = kwp_pkg::STATUS_MORE;

      if (carb) begin
         step_result.status = kwp_pkg::STATUS_ERROR;
         header_index_in  = 3'd0;
         header_length_in = 3'd0;
         data_length_in   = 8'd0;
         data_index_in    = 8'd0;
         running_sum_in   = 8'd0;
         target_in        = 8'd0;
         source_in        = 8'd0;
         address_in       = 1'b0;
      end else if (header_index_ff != hlen_eff) begin
         if (addr_eff && header_index_ff == 3'd1) begin
            target_in = step_byte;
         end else if (addr_eff && header_index_ff == 3'd2) begin
            source_in = step_byte;
         end
         header_index_in = hidx_next;
         running_sum_in  = sum_next;
         // The separate length byte closes the header.
         if (dlen_eff == 8'd0 && hidx_next == hlen_eff) begin
            data_length_in = step_byte;
         end
      end else if (data_index_ff < dlen_eff) begin
         step_result.payload_valid = 1'b1;
         step_result.payload_byte  = step_byte;
         step_result.payload_index = data_index_ff;
         running_sum_in            = sum_next;
         data_index_in             = data_index_ff + 8'd1;
      end else begin
         // Checksum byte: report and clear for the next frame.
         if (running_sum_ff == step_byte) begin
            step_result.status         = kwp_pkg::STATUS_DONE;
            step_result.payload_length = dlen_eff;
            step_result.has_addresses  = addr_eff;
            step_result.target_address = addr_eff ? target_ff : 8'd0;
            step_result.source_address = addr_eff ? source_ff : 8'd0;
         end else begin
            step_result.status = kwp_pkg::STATUS_ERROR;
         end
         header_index_in  = 3'd0;
         header_length_in = 3'd0;
         data_length_in   = 8'd0;
         data_index_in    = 8'd0;
         running_sum_in   = 8'd0;
         target_in        = 8'd0;
         source_in        = 8'd0;
         address_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff  <= 3'd0;
         header_length_ff <= 3'd0;
         data_length_ff   <= 8'd0;
         data_index_ff    <= 8'd0;
         running_sum_ff   <= 8'd0;
         target_ff        <= 8'd0;
         source_ff        <= 8'd0;
         address_ff       <= 1'b0;
      end else if (step_valid) begin
         header_index_ff  <= header_index_in;
         header_length_ff <= header_length_in;
         data_length_ff   <= data_length_in;
         data_index_ff    <= data_index_in;
         running_sum_ff   <= running_sum_in;
         target_ff        <= target_in;
         source_ff        <= source_in;
         address_ff       <= address_in;
      end
   end

   `KWP_ASSERT_NOW(a_header_bound, clock, reset, 1'b1, header_index_ff <= 3'd4, "header index beyond four")
   `KWP_ASSERT_NOW(a_index_bound, clock, reset, 1'b1, data_index_ff <= data_length_ff, "payload index passed length")
   `KWP_ASSERT_NOW(a_payload_phase, clock, reset, step_valid && step_result.payload_valid, step_result.status == kwp_pkg::STATUS_MORE && header_index_ff == header_length_ff, "payload outside data phase")
   `KWP_ASSERT_NEXT(a_clear_after_end, clock, reset, step_valid && step_result.status != kwp_pkg::STATUS_MORE, header_index_ff == 3'd0 && running_sum_ff == 8'd0 && data_index_ff == 8'd0, "frame state not cleared")

endmodule

`default_nettype wire

[hw/rtl/kwp2000_frame_receiver.sv]
// Top level of the ISO 14230 (KWP2000) byte-serial frame receiver.
// Depends on kwp_pkg and kwp_deframer.
//
//   channel | direction | handshake             | beat carries
//   req     | in        | req_valid / req_ready | one received byte (req_rx_byte)
//   rsp     | out       | rsp_valid / rsp_ready | status and payload/header fields
//
// One byte is taken per cycle unless a stalled response holds it up; each
// byte yields exactly one response beat. A byte waits in the input register,
// is deframed by the frame state logic and lands in the response register,
// from which the response is presented. Reset is synchronous and clears all
// frame state.
// A stalled response holds the input register, and the input side keeps
// accepting as long as that register is free or moving on in the same cycle.
`default_nettype none

module kwp2000_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [1:0] rsp_status,
   output      logic       rsp_payload_valid,
   output      logic [7:0] rsp_payload_byte,
   output      logic [7:0] rsp_payload_index,
   output      logic [7:0] rsp_payload_length,
   output      logic       rsp_has_addresses,
   output      logic [7:0] rsp_target_address,
   output      logic [7:0] rsp_source_address
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   kwp_pkg::result_type out_result_ff;
   kwp_pkg::result_type step_result;
   logic                advance;

   // The held byte moves on when the response register is empty or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   kwp_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_byte   (in_byte_ff),
      .step_result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; the valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_result_ff.status;
   assign rsp_payload_valid  = out_result_ff.payload_valid;
   assign rsp_payload_byte   = out_result_ff.payload_byte;
   assign rsp_payload_index  = out_result_ff.payload_index;
   assign rsp_payload_length = out_result_ff.payload_length;
   assign rsp_has_addresses  = out_result_ff.has_addresses;
   assign rsp_target_address = out_result_ff.target_address;
   assign rsp_source_address = out_result_ff.source_address;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ISO 14230 frame receiver (kwp2000_frame_receiver).
// Depends on kwp_pkg for the status codes, format byte masks and the response layout.

module tb_top;

   localparam int ITEM_TARGET  = 900;
   // Long receiver hold-off that fills the pipeline and stalls the byte input.
   localparam int HOLD_CYCLES  = 300;
   // Longest legal stretch without a beat is the hold-off plus a couple of
   // idle bursts; the watchdog allows several times that.
   localparam int STALL_LIMIT  = 2000;
   // Extra wait at the end, after every expected response has been checked.
   localparam int DRAIN_CYCLES = 10;

   // One row of the directed table. When pinned is set, the response is the
   // one typed into the row; otherwise the frame predictor supplies it.
   typedef struct packed {
      logic [7:0]          rx_byte;
      logic                pinned;
      kwp_pkg::result_type want;
   } stim_row_type;

   localparam kwp_pkg::result_type R_MORE =
      '{kwp_pkg::STATUS_MORE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
   localparam kwp_pkg::result_type R_ERROR =
      '{kwp_pkg::STATUS_ERROR, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // CARB format bytes, with and without length bits, are refused at once.
      '{8'h40, 1'b1, R_ERROR},
      '{8'h7F, 1'b1, R_ERROR},
      // Plain header with a two-byte payload and a good checksum.
      '{8'h02, 1'b1, R_MORE},
      '{8'h11, 1'b1, '{kwp_pkg::STATUS_MORE, 1'b1, 8'h11, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{8'h22, 1'b1, '{kwp_pkg::STATUS_MORE, 1'b1, 8'h22, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{8'h35, 1'b1, '{kwp_pkg::STATUS_DONE, 1'b0, 8'h00, 8'h00, 8'h02, 1'b0, 8'h00, 8'h00}},
      // Addressed header with a separate length byte of zero: no payload at
      // all, so the byte after the length is already the checksum.
      '{8'h80, 1'b1, R_MORE},
      '{8'hFF, 1'b1, R_MORE},
      '{8'h00, 1'b1, R_MORE},
      '{8'h00, 1'b1, R_MORE},
      '{8'h7F, 1'b1, '{kwp_pkg::STATUS_DONE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h00}},
      // One payload byte followed by a wrong checksum.
      '{8'h01, 1'b1, R_MORE},
      '{8'hAA, 1'b1, '{kwp_pkg::STATUS_MORE, 1'b1, 8'hAA, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{8'h00, 1'b1, R_ERROR},
      // Both mode bits set still means addressed; left to the predictor.
      '{8'hC1, 1'b0, R_MORE},
      '{8'h33, 1'b0, R_MORE},
      '{8'hF1, 1'b0, R_MORE},
      '{8'h00, 1'b0, R_MORE},
      '{8'hE5, 1'b0, R_MORE},
      // Unaddressed header with a separate, non-zero length byte.
      '{8'h00, 1'b0, R_MORE},
      '{8'h01, 1'b0, R_MORE},
      '{8'h5A, 1'b0, R_MORE},
      '{8'h5B, 1'b0, R_MORE}
   };

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_payload_valid;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic [7:0] rsp_payload_length;
   logic       rsp_has_addresses;
   logic [7:0] rsp_target_address;
   logic [7:0] rsp_source_address;

   kwp2000_frame_receiver u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_payload_length (rsp_payload_length),
      .rsp_has_addresses  (rsp_has_addresses),
      .rsp_target_address (rsp_target_address),
      .rsp_source_address (rsp_source_address)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Frame predictor. It keeps its own copy of the deframer state and is
   // advanced once for every byte beat that the block accepts.
   // ---------------------------------------------------------------------
   logic [2:0] hdr_count;    // header bytes seen in the current frame
   logic [2:0] hdr_total;    // header length announced by the format byte
   logic [7:0] pay_total;    // payload length of the current frame
   logic [8:0] pay_count;    // payload bytes seen so far
   logic [7:0] frame_sum;    // running modulo-256 sum of header and payload
   logic [7:0] tgt_addr;
   logic [7:0] src_addr;
   logic       addr_mode;

   kwp_pkg::result_type expected_results[$];
   int                  mismatches = 0;
   int                  bytes_sent = 0;

   function automatic void clear_frame_state();
      hdr_count = '0;
      hdr_total = '0;
      pay_total = '0;
      pay_count = '0;
      frame_sum = '0;
      tgt_addr  = '0;
      src_addr  = '0;
      addr_mode = 1'b0;
   endfunction

   function automatic kwp_pkg::result_type deframe_byte(input logic [7:0] b);
      kwp_pkg::result_type r;
      r = '0;
      r.status = kwp_pkg::STATUS_MORE;

      // The first byte of a frame is the format byte.
      if (hdr_count == 0) begin
         hdr_total = 3'd1;
         pay_total = 8'h00;
         if ((b & kwp_pkg::FMT_MODE_MASK) == kwp_pkg::FMT_MODE_CARB) begin
            clear_frame_state();
            r.status = kwp_pkg::STATUS_ERROR;
            return r;
         end
         addr_mode = (b & kwp_pkg::FMT_ADDR_BIT) != 8'h00;
         if (addr_mode)
            hdr_total = hdr_total + 3'd2;
         if ((b & kwp_pkg::FMT_LEN_MASK) == 8'h00)
            hdr_total = hdr_total + 3'd1;
         else
            pay_total = b & kwp_pkg::FMT_LEN_MASK;
      end

      if (hdr_count != hdr_total) begin
         if (addr_mode && hdr_count == 3'd1)
            tgt_addr = b;
         else if (addr_mode && hdr_count == 3'd2)
            src_addr = b;
         hdr_count = hdr_count + 3'd1;
         frame_sum = frame_sum + b;
         // A separate length byte closes the header.
         if (pay_total == 8'h00 && hdr_count == hdr_total)
            pay_total = b;
      end else if (pay_count < {1'b0, pay_total}) begin
         r.payload_valid = 1'b1;
         r.payload_byte  = b;
         r.payload_index = pay_count[7:0];
         frame_sum = frame_sum + b;
         pay_count = pay_count + 9'd1;
      end else begin
         // Checksum byte: the frame ends here either way.
         if (frame_sum == b) begin
            r.status         = kwp_pkg::STATUS_DONE;
            r.payload_length = pay_total;
            r.has_addresses  = addr_mode;
            if (addr_mode) begin
               r.target_address = tgt_addr;
               r.source_address = src_addr;
            end
         end else begin
            r.status = kwp_pkg::STATUS_ERROR;
         end
         clear_frame_state();
      end
      return r;
   endfunction

   initial clear_frame_state();

   // ---------------------------------------------------------------------
   // Byte sender. Bursts of idle cycles are inserted with probability
   // src_pct before a beat; valid then stays high until the beat is taken.
   // ---------------------------------------------------------------------
   int src_pct  = 0;
   int sink_pct = 0;
   int hold_asked = 0;

   task automatic send_byte(input logic [7:0] b, input logic pinned,
                            input kwp_pkg::result_type pinned_res);
      kwp_pkg::result_type predicted;
      int gap;
      if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The beat was taken at this edge: advance the predictor with it.
      predicted = deframe_byte(b);
      expected_results.push_back(pinned ? pinned_res : predicted);
      bytes_sent++;
   endtask

   // A well-formed frame with random content. A payload length of -1 picks
   // one at random, mostly short ones. About one frame in ten carries a
   // corrupted checksum.
   task automatic send_frame(input int want_len);
      logic [7:0] body[$];
      logic [7:0] sum;
      logic       addr;
      logic       split_len;
      int         n;
      int         pick;
      addr = 1'($urandom_range(0, 1));
      n = want_len;
      if (n < 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            n = $urandom_range(0, 6);
         else if (pick < 95)
            n = $urandom_range(7, 63);
         else if (pick < 99)
            n = $urandom_range(64, 127);
         else
            n = $urandom_range(200, 255);
      end
      // Lengths of zero or above 63 only fit in a separate length byte.
      split_len = (n == 0 || n > 63) ? 1'b1 : ($urandom_range(0, 3) == 0);
      body.push_back({addr, addr & 1'($urandom_range(0, 1)),
                      split_len ? 6'd0 : 6'(n)});
      if (addr) begin
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
      end
      if (split_len)
         body.push_back(8'(n));
      repeat (n) body.push_back(8'($urandom));
      sum = '0;
      foreach (body[i]) sum = sum + body[i];
      if ($urandom_range(0, 9) == 0)
         sum = sum ^ 8'($urandom_range(1, 255));
      body.push_back(sum);
      foreach (body[i]) send_byte(body[i], 1'b0, '0);
   endtask

   // Stray bytes, then random filler until the deframer is back at the
   // start of a frame, so that the next frame lines up.
   task automatic send_noise();
      int k;
      k = $urandom_range(1, 2);
      repeat (k) send_byte(8'($urandom), 1'b0, '0);
      while (hdr_count != 0) send_byte(8'($urandom), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------------
   // Response side: checks every response beat against the oldest
   // expectation and drives rsp_ready with random stalls and one long
   // hold-off on request.
   // ---------------------------------------------------------------------
   int hold_granted = 0;
   int hold_left    = 0;
   int stall_left   = 0;

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result();
      kwp_pkg::result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: response beat with none expected, actual status %0h",
                  $time, rsp_status);
         mismatches++;
         return;
      end
      want = expected_results.pop_front();
      compare_field("status",         8'(want.status),         8'(rsp_status));
      compare_field("payload_valid",  8'(want.payload_valid),  8'(rsp_payload_valid));
      compare_field("payload_byte",   want.payload_byte,       rsp_payload_byte);
      compare_field("payload_index",  want.payload_index,      rsp_payload_index);
      compare_field("payload_length", want.payload_length,     rsp_payload_length);
      compare_field("has_addresses",  8'(want.has_addresses),  8'(rsp_has_addresses));
      compare_field("target_address", want.target_address,     rsp_target_address);
      compare_field("source_address", want.source_address,     rsp_source_address);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      if (hold_granted != hold_asked) begin
         hold_granted = hold_asked;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequence.
   // ---------------------------------------------------------------------
   initial begin
      int  pick;
      bit  pressure_done;
      pressure_done = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table first, with moderate idling on both sides.
      src_pct  = 30;
      sink_pct = 30;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(DIRECTED[i].rx_byte, DIRECTED[i].pinned, DIRECTED[i].want);

      // Longest payloads: the 6-bit length maximum and the separate-byte one.
      send_frame(63);
      send_frame(255);

      while (bytes_sent < ITEM_TARGET) begin
         // Idling changes by phase; the tail of the run has none at all.
         if (bytes_sent < 250) begin
            src_pct = 25; sink_pct = 25;
         end else if (bytes_sent < 450) begin
            src_pct = 0;  sink_pct = 40;
         end else if (bytes_sent < 550) begin
            src_pct = 50; sink_pct = 0;
         end else if (bytes_sent < 750) begin
            src_pct = 20; sink_pct = 20;
         end else begin
            src_pct = 0;  sink_pct = 0;
         end

         // Once, hold the receiver off while bytes keep coming in.
         if (!pressure_done && bytes_sent >= 300) begin
            hold_asked++;
            pressure_done = 1'b1;
         end

         pick = $urandom_range(0, 99);
         if (pick < 4)
            send_noise();
         else if (pick < 10)
            send_byte({2'b01, 6'($urandom)}, 1'b0, '0);
         else
            send_frame(-1);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/kwp_pkg.sv
hw/rtl/kwp_deframer.sv
hw/rtl/kwp2000_frame_receiver.sv
tb/tb_top.sv
